### rtl/mqtt_packet_receive_parser_macros.svh
// Assertion macros shared by the MQTT receive parser checker.
// Depends on nothing; every macro expects clk and rst in the enclosing scope.
`ifndef MQTT_PACKET_RECEIVE_PARSER_MACROS_SVH
`define MQTT_PACKET_RECEIVE_PARSER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define MQTTP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define MQTTP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/mqttp_pkg.sv
// Package for the MQTT receive parser: phase codes, parser state, result
// record and configuration register indexes. Depends on nothing.
package mqttp_pkg;

  typedef enum logic [4:0] {
    PH_HEADER   = 5'b00001,
    PH_LENGTH   = 5'b00010,
    PH_TOPIC_HI = 5'b00100,
    PH_TOPIC_LO = 5'b01000,
    PH_BODY     = 5'b10000
  } phase_t;

  localparam logic CFG_BUFFER_SIZE   = 1'b0;
  localparam logic CFG_STREAM_ENABLE = 1'b1;

  localparam logic [15:0] BUFFER_SIZE_RESET = 16'd256;
  localparam logic [3:0]  PUBLISH_TYPE      = 4'h3;

  typedef struct packed {
    logic [15:0] buffer_size;
    logic        stream_enable;
  } cfg_t;

  typedef struct packed {
    phase_t      phase;
    logic [3:0]  type_nibble;
    logic        publish_flag;
    logic        qos1_flag;
    logic [2:0]  length_bytes_seen;
    logic [27:0] remaining_length;
    logic [27:0] body_count;
    logic [16:0] skip_count;
    logic [15:0] store_count;
    logic [28:0] total_index;
    logic [7:0]  topic_len_high;
  } state_t;

  typedef struct packed {
    logic        store_write;
    logic [15:0] store_addr;
    logic        forward_valid;
    logic [7:0]  out_byte;
    logic        packet_end;
    logic [3:0]  packet_type;
    logic [2:0]  length_field_bytes;
    logic [15:0] stored_length;
    logic        malformed;
  } result_t;

endpackage

### rtl/mqttp_ifs.sv
// Valid/ready channel interfaces of the MQTT receive parser: the received
// byte stream and the per-byte result stream. Depends on nothing.
interface mqttp_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface mqttp_res_if;
  logic        valid;
  logic        ready;
  logic        store_write;
  logic [15:0] store_addr;
  logic        forward_valid;
  logic [7:0]  out_byte;
  logic        packet_end;
  logic [3:0]  packet_type;
  logic [2:0]  length_field_bytes;
  logic [15:0] stored_length;
  logic        malformed;

  modport source (
    output valid, output store_write, output store_addr, output forward_valid,
    output out_byte, output packet_end, output packet_type,
    output length_field_bytes, output stored_length, output malformed,
    input ready
  );
  modport sink (
    input valid, input store_write, input store_addr, input forward_valid,
    input out_byte, input packet_end, input packet_type,
    input length_field_bytes, input stored_length, input malformed,
    output ready
  );
endinterface

### rtl/mqtt_packet_receive_parser.sv
// Top level of the MQTT receive parser: input byte register, parser state, result register
// and configuration registers. Depends on mqttp_pkg, mqttp_ifs and mqttp_step.
//
// Usage: received MQTT bytes enter one per request on the rx channel
// (valid/ready, field rx_byte). For every byte the block returns exactly
// one result request on the res channel: the store write and address, the
// payload forward flag, an echo of the byte and, on the last byte of a
// packet, the packet-end report (type, length-field size, stored length,
// malformed flag).
// Pipeline: two register stages in all, the input byte register and the
// result register. Throughput: one byte per cycle while res.ready keeps
// taking results; all per-byte work is one pass of counter and compare
// logic between the input byte register and the result register.
// Stalls: the input register and the result register decouple the sides,
// so a new byte is still taken while a finished result waits; when both
// are full, rx.ready drops until res.ready takes the pending result.
// Reset (rst, synchronous, active high) empties both registers, returns
// the parser to waiting for a header byte and loads buffer_size = 256 and
// stream_enable = 0. Configuration writes (cfg_we, cfg_index, cfg_data) take effect at
// the next edge; the user must make them while the block is idle; no logic enforces this.
module mqtt_packet_receive_parser #(
  parameter int MAX_LENGTH_BYTES = 4
) (
  input  logic        clk,
  input  logic        rst,
  mqttp_rx_if.sink    rx,
  mqttp_res_if.source res,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);
  import mqttp_pkg::*;

  cfg_t    cfg;
  state_t  st;
  state_t  st_next;
  result_t step_res;
  result_t out_res;
  logic    in_full;
  logic    out_valid;
  logic [7:0] in_byte;
  logic    process_fire;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{buffer_size: BUFFER_SIZE_RESET, stream_enable: 1'b0};
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BUFFER_SIZE:   cfg.buffer_size   <= cfg_data;
        CFG_STREAM_ENABLE: cfg.stream_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // The held byte is parsed whenever the result register is free or is
  // being emptied in this same cycle.
  assign process_fire = in_full && (!out_valid || res.ready);
  assign rx.ready     = !in_full || process_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (rx.valid && rx.ready) begin
      in_full <= 1'b1;
    end else if (process_fire) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) begin
      in_byte <= rx.rx_byte;
    end
  end

  mqttp_step #(
    .MAX_LENGTH_BYTES(MAX_LENGTH_BYTES)
  ) u_step (
    .cfg    (cfg),
    .st     (st),
    .rx_byte(in_byte),
    .st_next(st_next),
    .res    (step_res)
  );

  // Parser state advances once per parsed byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '{phase: PH_HEADER, type_nibble: '0, publish_flag: 1'b0, qos1_flag: 1'b0,
              length_bytes_seen: '0, remaining_length: '0, body_count: '0,
              skip_count: '0, store_count: '0, total_index: '0, topic_len_high: '0};
    end else if (process_fire) begin
      st <= st_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (process_fire) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (process_fire) begin
      out_res <= step_res;
    end
  end

  assign res.valid              = out_valid;
  assign res.store_write        = out_res.store_write;
  assign res.store_addr         = out_res.store_addr;
  assign res.forward_valid      = out_res.forward_valid;
  assign res.out_byte           = out_res.out_byte;
  assign res.packet_end         = out_res.packet_end;
  assign res.packet_type        = out_res.packet_type;
  assign res.length_field_bytes = out_res.length_field_bytes;
  assign res.stored_length      = out_res.stored_length;
  assign res.malformed          = out_res.malformed;

endmodule

### rtl/mqttp_step.sv
// Per-byte parser logic: next state and result record from the current
// state, configuration and one received byte. Depends on mqttp_pkg.
module mqttp_step #(
  parameter int MAX_LENGTH_BYTES = 4
) (
  input  mqttp_pkg::cfg_t    cfg,
  input  mqttp_pkg::state_t  st,
  input  logic [7:0]         rx_byte,
  output mqttp_pkg::state_t  st_next,
  output mqttp_pkg::result_t res
);
  import mqttp_pkg::*;

  always_comb begin
    state_t      cur;
    state_t      nxt;
    logic [27:0] contrib;
    logic [27:0] rem_new;
    logic [2:0]  lbs_inc;
    logic [27:0] body_inc;
    logic        wr;
    logic        fin;
    logic        bad;
    logic        fwd;

    cur = st;
    // A header byte starts a fresh packet: all counters begin at zero.
    if (st.phase == PH_HEADER) begin
      cur.store_count       = '0;
      cur.total_index       = '0;
      cur.length_bytes_seen = '0;
      cur.remaining_length  = '0;
      cur.body_count        = '0;
      cur.skip_count        = '0;
      cur.topic_len_high    = '0;
    end
    nxt = cur;
    fin = 1'b0;
    bad = 1'b0;
    fwd = 1'b0;

    wr = (cur.store_count < cfg.buffer_size);
    if (wr) begin
      nxt.store_count = cur.store_count + 16'd1;
    end

    unique case (cur.length_bytes_seen[1:0])
      2'd0: contrib = {21'd0, rx_byte[6:0]};
      2'd1: contrib = {14'd0, rx_byte[6:0], 7'd0};
      2'd2: contrib = {7'd0, rx_byte[6:0], 14'd0};
      2'd3: contrib = {rx_byte[6:0], 21'd0};
      default: contrib = '0;
    endcase
    if (cur.length_bytes_seen[2]) begin
      contrib = '0;
    end
    rem_new  = cur.remaining_length | contrib;
    lbs_inc  = cur.length_bytes_seen + 3'd1;
    body_inc = cur.body_count + 28'd1;

    unique case (st.phase)
      PH_HEADER: begin
        nxt.type_nibble  = rx_byte[7:4];
        nxt.publish_flag = (rx_byte[7:4] == PUBLISH_TYPE);
        nxt.qos1_flag    = rx_byte[1];
        nxt.phase        = PH_LENGTH;
      end
      PH_LENGTH: begin
        nxt.remaining_length  = rem_new;
        nxt.length_bytes_seen = lbs_inc;
        if (rx_byte[7]) begin
          if (lbs_inc >= 3'(MAX_LENGTH_BYTES)) begin
            fin = 1'b1;
            bad = 1'b1;
          end
        end else if (cur.publish_flag) begin
          nxt.phase = PH_TOPIC_HI;
        end else if (rem_new == '0) begin
          fin = 1'b1;
        end else begin
          nxt.body_count = '0;
          nxt.phase      = PH_BODY;
        end
      end
      PH_TOPIC_HI: begin
        nxt.topic_len_high = rx_byte;
        nxt.phase          = PH_TOPIC_LO;
      end
      PH_TOPIC_LO: begin
        nxt.skip_count = {1'b0, cur.topic_len_high, rx_byte}
                         + (cur.qos1_flag ? 17'd2 : 17'd0);
        nxt.body_count = 28'd2;
        if (cur.remaining_length <= 28'd2) begin
          fin = 1'b1;
        end else begin
          nxt.phase = PH_BODY;
        end
      end
      PH_BODY: begin
        // Payload position counts from the second topic-length byte.
        fwd = cfg.stream_enable && cur.publish_flag &&
              ((cur.total_index - {26'd0, cur.length_bytes_seen} - 29'd2)
               > {12'd0, cur.skip_count});
        nxt.body_count = body_inc;
        if (body_inc >= cur.remaining_length) begin
          fin = 1'b1;
        end
      end
      default: begin
        nxt.phase = PH_HEADER;
      end
    endcase

    nxt.total_index = cur.total_index + 29'd1;

    res                    = '0;
    res.store_write        = wr;
    res.store_addr         = wr ? cur.store_count : 16'd0;
    res.forward_valid      = fwd;
    res.out_byte           = rx_byte;
    res.packet_end         = fin;
    res.packet_type        = nxt.type_nibble;
    res.malformed          = bad;
    if (fin) begin
      res.length_field_bytes = nxt.length_bytes_seen;
      if (bad) begin
        res.stored_length = '0;
      end else if (!cfg.stream_enable &&
                   (cur.total_index >= {13'd0, cfg.buffer_size})) begin
        res.stored_length = '0;
      end else begin
        res.stored_length = nxt.store_count;
      end
      nxt.phase = PH_HEADER;
    end

    st_next = nxt;
  end

endmodule

### rtl/mqttp_checker.sv
// Port-level checker for the MQTT receive parser and its bind statement.
// Depends on mqtt_packet_receive_parser_macros.svh.
`include "mqtt_packet_receive_parser_macros.svh"

module mqttp_checker #(
  parameter int MAX_LENGTH_BYTES = 4
) (
  input logic        clk,
  input logic        rst,
  input logic        res_valid,
  input logic        res_ready,
  input logic        store_write,
  input logic [15:0] store_addr,
  input logic        packet_end,
  input logic [2:0]  length_field_bytes,
  input logic [15:0] stored_length,
  input logic        malformed
);

  // End-of-packet report fields stay zero on bytes inside a packet.
  `MQTTP_ASSERT_NOW(a_mid_report_zero, res_valid && !packet_end, (length_field_bytes == 3'd0) && (stored_length == 16'd0) && !malformed, "report fields set inside a packet")

  // A too-long length field ends the packet and reports a stored length of zero.
  `MQTTP_ASSERT_NOW(a_malformed_report, res_valid && malformed, packet_end && (stored_length == 16'd0) && (length_field_bytes == 3'(MAX_LENGTH_BYTES)), "malformed report inconsistent")

  // A byte that is not stored carries address zero.
  `MQTTP_ASSERT_NOW(a_no_write_addr, res_valid && !store_write, store_addr == 16'd0, "address without store write")

  // A stalled result stays offered.
  `MQTTP_ASSERT_NEXT(a_stall_hold, res_valid && !res_ready, res_valid && $stable(store_addr) && $stable(stored_length), "stalled result changed")

endmodule

bind mqtt_packet_receive_parser mqttp_checker #(
  .MAX_LENGTH_BYTES(MAX_LENGTH_BYTES)
) u_mqttp_checker (
  .clk               (clk),
  .rst               (rst),
  .res_valid         (res.valid),
  .res_ready         (res.ready),
  .store_write       (res.store_write),
  .store_addr        (res.store_addr),
  .packet_end        (res.packet_end),
  .length_field_bytes(res.length_field_bytes),
  .stored_length     (res.stored_length),
  .malformed         (res.malformed)
);
